FILE: rtl/dfs_pkg.sv
// shared types, widths, codes and reset values of the deadline fault supervisor
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;

   localparam int MISS_COUNT_BITS     = 8;
   localparam int RECOVERY_COUNT_BITS = 10;

   localparam int RESP_W    = 32;
   localparam int TIME_W    = 40;
   localparam int CSR_W     = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W = 3;

   localparam logic [MISS_COUNT_BITS-1:0]     MISS_MAX = '1;
   localparam logic [RECOVERY_COUNT_BITS-1:0] REC_MAX  = '1;

   // operation codes
   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_ACK    = 1'b1;

   // fault reasons
   localparam logic REASON_NONE    = 1'b0;
   localparam logic REASON_OVERRUN = 1'b1;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_DEADLINE = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DEGRADE  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SAFE     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RECOVERY = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_HOLDOFF  = 3'd4;

   // register reset values
   localparam logic [RESP_W-1:0]              DEADLINE_RST = 32'd20000000;
   localparam logic [MISS_COUNT_BITS-1:0]     DEGRADE_RST  = MISS_COUNT_BITS'(1);
   localparam logic [MISS_COUNT_BITS-1:0]     SAFE_RST     = MISS_COUNT_BITS'(3);
   localparam logic [RECOVERY_COUNT_BITS-1:0] RECOVERY_RST = RECOVERY_COUNT_BITS'(25);
   localparam logic [TIME_W-1:0]              HOLDOFF_RST  = 40'd6000000000;

   typedef enum logic [1:0] {
      ST_NORMAL   = 2'd0,
      ST_DEGRADED = 2'd1,
      ST_SAFE     = 2'd2
   } state_type;

   typedef struct packed {
      logic [RESP_W-1:0]              deadline_limit;
      logic [MISS_COUNT_BITS-1:0]     degrade_threshold;
      logic [MISS_COUNT_BITS-1:0]     safe_threshold;
      logic [RECOVERY_COUNT_BITS-1:0] recovery_threshold;
      logic [TIME_W-1:0]              holdoff_end_ns;
   } cfg_type;

   typedef struct packed {
      logic              operation;
      logic [RESP_W-1:0] response_time;
      logic [TIME_W-1:0] elapsed_time;
   } item_type;

   typedef struct packed {
      logic [1:0]                     system_state;
      logic                           overrun;
      logic                           state_changed;
      logic [1:0]                     state_before;
      logic                           fault_reason;
      logic                           center_request;
      logic [MISS_COUNT_BITS-1:0]     miss_run;
      logic [RECOVERY_COUNT_BITS-1:0] good_run;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/dfs_if.sv
// request and response channel interfaces of the deadline fault supervisor
`timescale 1ns / 1ps
`default_nettype none
interface dfs_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [dfs_pkg::RESP_W-1:0] response_time;
   logic [dfs_pkg::TIME_W-1:0] elapsed_time;

   modport source (output valid, output operation, output response_time,
                   output elapsed_time, input ready);
   modport sink   (input valid, input operation, input response_time,
                   input elapsed_time, output ready);
endinterface

interface dfs_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              system_state;
   logic                                    overrun;
   logic                                    state_changed;
   logic [1:0]                              state_before;
   logic                                    fault_reason;
   logic                                    center_request;
   logic [dfs_pkg::MISS_COUNT_BITS-1:0]     miss_run;
   logic [dfs_pkg::RECOVERY_COUNT_BITS-1:0] good_run;

   modport source (output valid, output system_state, output overrun,
                   output state_changed, output state_before, output fault_reason,
                   output center_request, output miss_run, output good_run,
                   input ready);
   modport sink   (input valid, input system_state, input overrun,
                   input state_changed, input state_before, input fault_reason,
                   input center_request, input miss_run, input good_run,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/dfs_csr.sv
// apb configuration registers of the deadline fault supervisor
`timescale 1ns / 1ps
`default_nettype none
module dfs_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [dfs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [dfs_pkg::CSR_W-1:0]        pwdata,
   output logic      [dfs_pkg::CSR_W-1:0]        prdata,
   output logic                                  pready,
   output dfs_pkg::cfg_type                      cfg
);
   import dfs_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  index;
   logic                  write_en;

   // 8-byte register spacing
   assign index    = paddr[CSR_ADDR_W-1:3];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_DEADLINE: cfg_in.deadline_limit     = pwdata[RESP_W-1:0];
            REG_DEGRADE:  cfg_in.degrade_threshold  = pwdata[MISS_COUNT_BITS-1:0];
            REG_SAFE:     cfg_in.safe_threshold     = pwdata[MISS_COUNT_BITS-1:0];
            REG_RECOVERY: cfg_in.recovery_threshold = pwdata[RECOVERY_COUNT_BITS-1:0];
            REG_HOLDOFF:  cfg_in.holdoff_end_ns     = pwdata[TIME_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_DEADLINE: prdata = CSR_W'(cfg_ff.deadline_limit);
         REG_DEGRADE:  prdata = CSR_W'(cfg_ff.degrade_threshold);
         REG_SAFE:     prdata = CSR_W'(cfg_ff.safe_threshold);
         REG_RECOVERY: prdata = CSR_W'(cfg_ff.recovery_threshold);
         REG_HOLDOFF:  prdata = CSR_W'(cfg_ff.holdoff_end_ns);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadline_limit     <= DEADLINE_RST;
         cfg_ff.degrade_threshold  <= DEGRADE_RST;
         cfg_ff.safe_threshold     <= SAFE_RST;
         cfg_ff.recovery_threshold <= RECOVERY_RST;
         cfg_ff.holdoff_end_ns     <= HOLDOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/dfs_engine.sv
// supervisor state registers and the per-transaction update logic
`timescale 1ns / 1ps
`default_nettype none
module dfs_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire dfs_pkg::item_type item,
   input  wire dfs_pkg::cfg_type  cfg,
   output dfs_pkg::result_type result
);
   import dfs_pkg::*;

   state_type                      state_ff, state_in;
   logic                           reason_ff, reason_in;
   logic [MISS_COUNT_BITS-1:0]     miss_ff, miss_in;
   logic [RECOVERY_COUNT_BITS-1:0] rec_ff, rec_in;
   logic                           pending_ff, pending_in;

   logic                           missed;
   logic                           changed;
   logic                           have_target;
   state_type                      target;
   logic                           why;

   always_comb begin
      miss_in     = miss_ff;
      rec_in      = rec_ff;
      pending_in  = pending_ff;
      state_in    = state_ff;
      reason_in   = reason_ff;
      missed      = 1'b0;
      changed     = 1'b0;
      have_target = 1'b0;
      target      = state_ff;
      why         = REASON_NONE;

      if (item.operation == OP_ACK) begin
         pending_in = 1'b0;
      end else begin
         missed = item.response_time > cfg.deadline_limit;
         if (missed) begin
            miss_in = (miss_ff == MISS_MAX) ? miss_ff : miss_ff + 1'b1;
            rec_in  = '0;
            why     = REASON_OVERRUN;
            if (miss_in >= cfg.safe_threshold) begin
               have_target = 1'b1;
               target      = ST_SAFE;
            end else if (miss_in >= cfg.degrade_threshold) begin
               have_target = 1'b1;
               target      = ST_DEGRADED;
            end
         end else begin
            miss_in = '0;
            if (state_ff != ST_NORMAL) begin
               if (item.elapsed_time < cfg.holdoff_end_ns) begin
                  rec_in = '0;
               end else begin
                  rec_in = (rec_ff == REC_MAX) ? rec_ff : rec_ff + 1'b1;
                  if (rec_in >= cfg.recovery_threshold) begin
                     have_target = 1'b1;
                     target      = ST_NORMAL;
                  end
               end
            end
         end
      end

      // a move to the present state keeps its reason
      if (have_target && target != state_ff) begin
         changed   = 1'b1;
         state_in  = target;
         reason_in = why;
         if (target == ST_SAFE) begin
            pending_in = 1'b1;
         end
      end

      result.system_state    = state_in;
      result.overrun         = missed;
      result.state_changed   = changed;
      result.state_before    = state_ff;
      result.fault_reason    = reason_in;
      result.center_request  = pending_in;
      result.miss_run        = miss_in;
      result.good_run        = rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_NORMAL;
         reason_ff  <= REASON_NONE;
         miss_ff    <= '0;
         rec_ff     <= '0;
         pending_ff <= 1'b0;
      end else if (advance) begin
         state_ff   <= state_in;
         reason_ff  <= reason_in;
         miss_ff    <= miss_in;
         rec_ff     <= rec_in;
         pending_ff <= pending_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/deadline_fault_supervisor_core.sv
// top level of the deadline fault supervisor: input stage, engine, result register
`timescale 1ns / 1ps
`default_nettype none
// a request transaction is registered in the input stage, then its result in the
//    result register once that is free; the result handshake follows both registers
// throughput: one transaction per cycle while the result side is ready; the state
//    update is compare and counter logic between the input and result registers
// reset (synchronous, active high): state normal, reason none, counters and
//    center request cleared, registers back to their defaults, both stages empty
module deadline_fault_supervisor_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   dfs_req_if.sink                             req_bus,
   dfs_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [dfs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [dfs_pkg::CSR_W-1:0]      csr_pwdata,
   output logic      [dfs_pkg::CSR_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import dfs_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   logic       out_free;
   logic       in_fire;
   logic       advance;

   // result register can take a new transaction when empty or draining
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   // input stage moves on into the result register
   assign advance  = item_valid_ff && out_free;
   // input stage refills in the same cycle it empties
   assign req_bus.ready = !item_valid_ff || out_free;
   assign in_fire       = req_bus.valid && req_bus.ready;

   dfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // state update happens when the registered transaction advances
   dfs_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_comb begin
      item_valid_in = item_valid_ff;
      if (in_fire) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (in_fire) begin
         item_ff.operation     <= req_bus.operation;
         item_ff.response_time <= req_bus.response_time;
         item_ff.elapsed_time  <= req_bus.elapsed_time;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.system_state    = rsp_ff.system_state;
   assign rsp_bus.overrun         = rsp_ff.overrun;
   assign rsp_bus.state_changed   = rsp_ff.state_changed;
   assign rsp_bus.state_before    = rsp_ff.state_before;
   assign rsp_bus.fault_reason    = rsp_ff.fault_reason;
   assign rsp_bus.center_request  = rsp_ff.center_request;
   assign rsp_bus.miss_run        = rsp_ff.miss_run;
   assign rsp_bus.good_run        = rsp_ff.good_run;

   // a reported transition really changes the state
   a_change_moves : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.state_changed |-> rsp_ff.system_state != rsp_ff.state_before)
      else $error("state_changed without a new state");

   // entering safe raises the center request
   a_safe_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.state_changed && rsp_ff.system_state == ST_SAFE
      |-> rsp_ff.center_request)
      else $error("safe entry without center request");

   // a miss leaves a nonzero miss count and no recovery count
   a_miss_counts : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overrun |-> rsp_ff.miss_run != '0 && rsp_ff.good_run == '0)
      else $error("miss not reflected in counters");

   // the result register only fills from the input stage
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      !$past(item_valid_ff) && !$past(rsp_valid_ff) |-> !rsp_valid_ff)
      else $error("result appeared without a transaction");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// self-checking testbench for the deadline fault supervisor core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import dfs_pkg::*;

   // run limits and settle time after the last expected result
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT   = 40;

   // an index past the register map, writes to it must be dropped
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

   logic clock;
   logic reset;

   dfs_req_if req_bus ();
   dfs_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_W-1:0]      csr_pwdata;
   logic [CSR_W-1:0]      csr_prdata;
   logic                  csr_pready;

   deadline_fault_supervisor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // supervisor state as the bench expects it
   cfg_type                        model_cfg;
   state_type                      model_state;
   logic                           model_reason;
   logic [MISS_COUNT_BITS-1:0]     model_misses;
   logic [RECOVERY_COUNT_BITS-1:0] model_goods;
   logic                           model_center;

   result_type expected_verdicts[$];

   int  error_count;
   int  cycle_count;
   int  verdict_count;
   int  miss_total;
   int  transition_total;
   int  ack_total;
   int  config_phases;
   bit  idle_on;
   int  stall_left;

   // running supervision clock for well-formed report sequences
   logic [TIME_W-1:0] timeline_ns;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_verdicts.size());
      $display("deadline_fault_supervisor_core regression: fail");
      $finish;
   end

   task automatic report_error(string msg);
      if (error_count < PRINT_LIMIT) $display("error at %0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_value(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_error($sformatf("%s got %0h want %0h", what, got, want));
   endtask

   // state change helper of the predictor, reason kept when already there
   function automatic logic enter_state(state_type target, logic why);
      if (target == model_state) return 1'b0;
      model_state  = target;
      model_reason = why;
      if (target == ST_SAFE) model_center = 1'b1;
      return 1'b1;
   endfunction

   // next verdict of the supervisor for one transaction, state updated in place
   function automatic result_type predict_verdict(logic op, logic [RESP_W-1:0] resp,
                                                  logic [TIME_W-1:0] stamp);
      result_type verdict;
      state_type  prior_state;
      logic       missed;
      logic       changed;
      prior_state = model_state;
      missed      = 1'b0;
      changed     = 1'b0;
      if (op == OP_ACK) begin
         model_center = 1'b0;
      end else begin
         missed = resp > model_cfg.deadline_limit;
         if (missed) begin
            if (model_misses != MISS_MAX) model_misses = model_misses + 1'b1;
            model_goods = '0;
            // safe wins over degraded, and a miss can pull safe back to degraded
            if (model_misses >= model_cfg.safe_threshold)
               changed = enter_state(ST_SAFE, REASON_OVERRUN);
            else if (model_misses >= model_cfg.degrade_threshold)
               changed = enter_state(ST_DEGRADED, REASON_OVERRUN);
         end else begin
            model_misses = '0;
            // in normal the good count is left alone
            if (model_state != ST_NORMAL) begin
               if (stamp < model_cfg.holdoff_end_ns) begin
                  model_goods = '0;
               end else begin
                  if (model_goods != REC_MAX) model_goods = model_goods + 1'b1;
                  if (model_goods >= model_cfg.recovery_threshold)
                     changed = enter_state(ST_NORMAL, REASON_NONE);
               end
            end
         end
      end
      verdict.system_state    = model_state;
      verdict.overrun         = missed;
      verdict.state_changed   = changed;
      verdict.state_before    = prior_state;
      verdict.fault_reason    = model_reason;
      verdict.center_request  = model_center;
      verdict.miss_run        = model_misses;
      verdict.good_run        = model_goods;
      return verdict;
   endfunction

   function automatic logic [CSR_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
         REG_DEADLINE: return CSR_W'(model_cfg.deadline_limit);
         REG_DEGRADE:  return CSR_W'(model_cfg.degrade_threshold);
         REG_SAFE:     return CSR_W'(model_cfg.safe_threshold);
         REG_RECOVERY: return CSR_W'(model_cfg.recovery_threshold);
         REG_HOLDOFF:  return CSR_W'(model_cfg.holdoff_end_ns);
         default:      return '0;
      endcase
   endfunction

   // monitor: mirrors register writes, checks results, predicts accepted requests
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         model_cfg.deadline_limit     = DEADLINE_RST;
         model_cfg.degrade_threshold  = DEGRADE_RST;
         model_cfg.safe_threshold     = SAFE_RST;
         model_cfg.recovery_threshold = RECOVERY_RST;
         model_cfg.holdoff_end_ns     = HOLDOFF_RST;
         model_state  = ST_NORMAL;
         model_reason = REASON_NONE;
         model_misses = '0;
         model_goods  = '0;
         model_center = 1'b0;
      end else begin
         // register write lands with the access phase, values masked to width
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:3])
               REG_DEADLINE: model_cfg.deadline_limit     = csr_pwdata[RESP_W-1:0];
               REG_DEGRADE:  model_cfg.degrade_threshold  = csr_pwdata[MISS_COUNT_BITS-1:0];
               REG_SAFE:     model_cfg.safe_threshold     = csr_pwdata[MISS_COUNT_BITS-1:0];
               REG_RECOVERY: model_cfg.recovery_threshold =
                                csr_pwdata[RECOVERY_COUNT_BITS-1:0];
               REG_HOLDOFF:  model_cfg.holdoff_end_ns     = csr_pwdata[TIME_W-1:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_verdicts.size() == 0) begin
               report_error("result transaction with nothing expected");
            end else begin
               want = expected_verdicts.pop_front();
               check_value("system_state", 64'(rsp_bus.system_state),
                           64'(want.system_state));
               check_value("overrun", 64'(rsp_bus.overrun), 64'(want.overrun));
               check_value("state_changed", 64'(rsp_bus.state_changed),
                           64'(want.state_changed));
               check_value("state_before", 64'(rsp_bus.state_before),
                           64'(want.state_before));
               check_value("fault_reason", 64'(rsp_bus.fault_reason),
                           64'(want.fault_reason));
               check_value("center_request", 64'(rsp_bus.center_request),
                           64'(want.center_request));
               check_value("miss_run", 64'(rsp_bus.miss_run), 64'(want.miss_run));
               check_value("good_run", 64'(rsp_bus.good_run), 64'(want.good_run));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = predict_verdict(req_bus.operation, req_bus.response_time,
                                   req_bus.elapsed_time);
            expected_verdicts.push_back(want);
            verdict_count++;
            if (req_bus.operation == OP_ACK) ack_total++;
            if (want.overrun) miss_total++;
            if (want.state_changed) transition_total++;
         end
      end
   end

   // result side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // one request transaction, called and returning at a falling edge
   task automatic send_item(logic op, logic [RESP_W-1:0] resp, logic [TIME_W-1:0] stamp);
      int gap;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.response_time <= resp;
      req_bus.elapsed_time  <= stamp;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // stop sending until every result is back and the pipeline has settled
   task automatic wait_quiet();
      req_bus.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic read_reg(logic [REG_IDX_W-1:0] idx, output logic [CSR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      value = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_reg(logic [REG_IDX_W-1:0] idx);
      logic [CSR_W-1:0] value;
      read_reg(idx, value);
      check_value($sformatf("register %0d readback", idx), value, reg_value(idx));
   endtask

   // only called while the block is quiet
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 3'b000});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      if (idx <= REG_HOLDOFF) check_reg(idx);
   endtask

   task automatic set_config(logic [RESP_W-1:0] deadline, logic [7:0] degrade,
                             logic [7:0] safe, logic [9:0] recovery,
                             logic [TIME_W-1:0] holdoff);
      wait_quiet();
      write_reg(REG_DEADLINE, CSR_W'(deadline));
      write_reg(REG_DEGRADE, CSR_W'(degrade));
      write_reg(REG_SAFE, CSR_W'(safe));
      write_reg(REG_RECOVERY, CSR_W'(recovery));
      write_reg(REG_HOLDOFF, CSR_W'(holdoff));
      config_phases++;
   endtask

   // periodic reports with random content, plus acks and some noise
   task automatic run_random(int count, int miss_pct, int ack_pct);
      logic              op;
      logic [RESP_W-1:0] resp;
      logic [RESP_W-1:0] limit;
      logic [TIME_W-1:0] stamp;
      for (int i = 0; i < count; i++) begin
         limit = model_cfg.deadline_limit;
         op = ($urandom_range(0, 99) < ack_pct) ? OP_ACK : OP_REPORT;
         if ($urandom_range(0, 99) < miss_pct && limit != '1) begin
            resp = $urandom_range(limit + 32'd1, 32'hFFFF_FFFF);
            // overruns just past the deadline are the usual case
            if ($urandom_range(0, 1) == 0 && limit < 32'hFFFF_0000)
               resp = limit + $urandom_range(1, 1000);
         end else begin
            resp = $urandom_range(0, limit);
            if ($urandom_range(0, 3) == 0) resp = limit;
         end
         if (miss_pct > 0 && miss_pct < 100 && $urandom_range(0, 99) < 3) resp = $urandom;
         if (op == OP_ACK) resp = $urandom;
         if ($urandom_range(0, 99) < 5) begin
            stamp = TIME_W'({$urandom, $urandom});
         end else begin
            timeline_ns = timeline_ns + $urandom_range(1, 65536);
            stamp = timeline_ns;
         end
         send_item(op, resp, stamp);
      end
   endtask

   task automatic test_register_defaults();
      check_reg(REG_DEADLINE);
      check_reg(REG_DEGRADE);
      check_reg(REG_SAFE);
      check_reg(REG_RECOVERY);
      check_reg(REG_HOLDOFF);
   endtask

   // escalation with reset thresholds: degraded, safe, back to degraded, acks
   task automatic test_escalation();
      send_item(OP_REPORT, 32'd0, 40'd0);
      send_item(OP_REPORT, 32'd20000000, 40'd1);
      send_item(OP_REPORT, 32'd20000001, 40'd2);
      send_item(OP_ACK, 32'd0, 40'd3);
      send_item(OP_REPORT, 32'hFFFF_FFFF, 40'd4);
      send_item(OP_REPORT, 32'd30000000, 40'd5);
      send_item(OP_REPORT, 32'd100, 40'd6);
      send_item(OP_REPORT, 32'd25000000, 40'd7);
      send_item(OP_ACK, 32'hFFFF_FFFF, 40'hFF_FFFF_FFFF);
      send_item(OP_ACK, 32'd0, 40'd0);
   endtask

   // hold-off boundary, recovery to normal, good count kept in normal
   task automatic test_recovery_holdoff();
      wait_quiet();
      write_reg(REG_RECOVERY, 64'd2);
      write_reg(REG_HOLDOFF, 64'd1000);
      send_item(OP_REPORT, 32'd5, 40'd999);
      send_item(OP_REPORT, 32'd5, 40'd1000);
      send_item(OP_REPORT, 32'd5, 40'hFF_FFFF_FFFF);
      send_item(OP_REPORT, 32'd5, 40'd2000);
   endtask

   // zero thresholds, width masking on writes, dropped unmapped write
   task automatic test_zero_thresholds();
      wait_quiet();
      write_reg(REG_DEGRADE, 64'hFFFF_FFFF_FFFF_FF00);
      write_reg(REG_SAFE, 64'h0);
      write_reg(REG_RECOVERY, 64'hFFFF_FFFF_FFFF_FC00);
      write_reg(REG_HOLDOFF, 64'h0);
      write_reg(REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF);
      test_register_defaults();
      send_item(OP_REPORT, 32'd0, 40'd10);
      send_item(OP_REPORT, 32'hFFFF_FFFF, 40'd11);
      send_item(OP_REPORT, 32'd0, 40'd12);
      send_item(OP_ACK, 32'd0, 40'd13);
   endtask

   // zero and full deadline, hold-off at its maximum
   task automatic test_deadline_extremes();
      wait_quiet();
      write_reg(REG_DEADLINE, 64'hABCD_0000_0000_0000);
      write_reg(REG_HOLDOFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_REPORT, 32'd0, 40'd20);
      send_item(OP_REPORT, 32'd1, 40'd21);
      send_item(OP_REPORT, 32'd0, 40'hFF_FFFF_FFFE);
      send_item(OP_REPORT, 32'd0, 40'hFF_FFFF_FFFF);
      wait_quiet();
      write_reg(REG_DEADLINE, 64'hFFFF_FFFF);
      send_item(OP_REPORT, 32'hFFFF_FFFF, 40'd30);
   endtask

   task automatic test_random_mixed();
      set_config($urandom_range(1000, 1 << 24), 8'd2, 8'd5, 10'd10,
                 timeline_ns + 40'd2_000_000);
      run_random(100, 30, 5);
      // thresholds in any order, safe below degrade included
      set_config($urandom_range(1000, 1 << 24), 8'($urandom_range(1, 8)),
                 8'($urandom_range(1, 8)), 10'($urandom_range(1, 16)),
                 timeline_ns + $urandom_range(0, 1 << 22));
      run_random(100, 35, 5);
   endtask

   task automatic test_zero_threshold_random();
      set_config($urandom, 8'd0, 8'd0, 10'd0, 40'd0);
      run_random(60, 40, 10);
   endtask

   // miss count runs into its ceiling, safe only at the top threshold
   task automatic test_miss_saturation();
      set_config(32'd0, 8'd200, 8'd255, 10'd1023, 40'd0);
      run_random(260, 100, 0);
      run_random(40, 50, 10);
   endtask

   // long recovery to the top threshold, good count kept once back in normal
   task automatic test_long_recovery();
      set_config(32'd50000, 8'd1, 8'd2, 10'd1023, 40'd0);
      run_random(3, 100, 0);
      run_random(1026, 0, 0);
   endtask

   // back-to-back transactions with no idling on either side
   task automatic test_steady_stream();
      idle_on = 1'b0;
      set_config($urandom, 8'd1, 8'd3, 10'd4, timeline_ns + 40'd500_000);
      run_random(100, 30, 5);
   endtask

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_REPORT;
      req_bus.response_time = '0;
      req_bus.elapsed_time  = '0;
      rsp_bus.ready         = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      error_count           = 0;
      cycle_count           = 0;
      verdict_count         = 0;
      miss_total            = 0;
      transition_total      = 0;
      ack_total             = 0;
      config_phases         = 0;
      stall_left            = 0;
      idle_on               = 1'b1;
      timeline_ns           = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_defaults();
      test_escalation();
      test_recovery_holdoff();
      test_zero_thresholds();
      test_deadline_extremes();
      test_random_mixed();
      test_zero_threshold_random();
      test_miss_saturation();
      test_long_recovery();
      test_steady_stream();
      wait_quiet();

      $display("checked %0d results: %0d misses, %0d state changes, %0d acks",
               verdict_count, miss_total, transition_total, ack_total);
      $display("%0d register settings incl. zero and full thresholds, %0d errors",
               config_phases, error_count);
      if (error_count == 0) begin
         $display("deadline_fault_supervisor_core regression: pass");
      end else begin
         $display("deadline_fault_supervisor_core regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
